FILE: design/isrp_pkg.sv
package isrp_pkg;

  // Store geometry
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the stream words
  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int RND_W    = 15;
  localparam int STAT_W   = 3;
  localparam int POS_W    = 6;
  localparam int RNDC_W   = $clog2(RND_W);
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PICK   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP         = 4'd0,
    OP_LOAD        = 4'd1,
    OP_SCAN        = 4'd2,
    OP_SET_NF      = 4'd3,
    OP_SET_FULL    = 4'd4,
    OP_APPEND      = 4'd5,
    OP_SET_PRESENT = 4'd6,
    OP_SET_HIT     = 4'd7,
    OP_RD_LAST     = 4'd8,
    OP_RM_WR       = 4'd9,
    OP_DIV_INIT    = 4'd10,
    OP_SET_EMPTY   = 4'd11,
    OP_DIV_STEP    = 4'd12,
    OP_RD_REM      = 4'd13,
    OP_PICK        = 4'd14,
    OP_PUBLISH     = 4'd15
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS   = 4'd0,
    C_NEVER    = 4'd1,
    C_ACC_SCAN = 4'd2,
    C_ACC_PICK = 4'd3,
    C_HIT      = 4'd4,
    C_MORE     = 4'd5,
    C_ADD_FULL = 4'd6,
    C_ADD      = 4'd7,
    C_REMOVE   = 4'd8,
    C_EMPTY    = 4'd9,
    C_DIV_MORE = 4'd10,
    C_OUT_BUSY = 4'd11
  } cond_t;

  // Program addresses
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_IDLE    = 5'd0;
  localparam logic [STEP_W-1:0] S_SCAN    = 5'd1;
  localparam logic [STEP_W-1:0] S_MISS    = 5'd2;
  localparam logic [STEP_W-1:0] S_NF      = 5'd3;
  localparam logic [STEP_W-1:0] S_FULL    = 5'd4;
  localparam logic [STEP_W-1:0] S_APPEND  = 5'd5;
  localparam logic [STEP_W-1:0] S_FOUND   = 5'd6;
  localparam logic [STEP_W-1:0] S_PRESENT = 5'd7;
  localparam logic [STEP_W-1:0] S_HITOK   = 5'd8;
  localparam logic [STEP_W-1:0] S_RM_RD   = 5'd9;
  localparam logic [STEP_W-1:0] S_RM_WR   = 5'd10;
  localparam logic [STEP_W-1:0] S_PICK    = 5'd11;
  localparam logic [STEP_W-1:0] S_EMPTY   = 5'd12;
  localparam logic [STEP_W-1:0] S_DIV     = 5'd13;
  localparam logic [STEP_W-1:0] S_PICK_RD = 5'd14;
  localparam logic [STEP_W-1:0] S_PICK_WT = 5'd15;
  localparam logic [STEP_W-1:0] S_DONE    = 5'd16;

  // One control word: operation, two conditional jumps, fall-through target
  typedef struct packed {
    op_t               op;
    cond_t             cond_a;
    logic [STEP_W-1:0] tgt_a;
    cond_t             cond_b;
    logic [STEP_W-1:0] tgt_b;
    logic [STEP_W-1:0] tgt_else;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
    ucode_t w;
    case (pc)
      S_IDLE:    w = '{OP_LOAD,        C_ACC_SCAN, S_SCAN,    C_ACC_PICK, S_PICK, S_IDLE};
      S_SCAN:    w = '{OP_SCAN,        C_HIT,      S_FOUND,   C_MORE,     S_SCAN, S_MISS};
      S_MISS:    w = '{OP_NOP,         C_ADD_FULL, S_FULL,    C_ADD,      S_APPEND, S_NF};
      S_NF:      w = '{OP_SET_NF,      C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_FULL:    w = '{OP_SET_FULL,    C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_APPEND:  w = '{OP_APPEND,      C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_FOUND:   w = '{OP_NOP,         C_ADD,      S_PRESENT, C_REMOVE,   S_RM_RD, S_HITOK};
      S_PRESENT: w = '{OP_SET_PRESENT, C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_HITOK:   w = '{OP_SET_HIT,     C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_RM_RD:   w = '{OP_RD_LAST,     C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_RM_WR};
      S_RM_WR:   w = '{OP_RM_WR,       C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_PICK:    w = '{OP_DIV_INIT,    C_EMPTY,    S_EMPTY,   C_NEVER,    S_IDLE, S_DIV};
      S_EMPTY:   w = '{OP_SET_EMPTY,   C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_DIV:     w = '{OP_DIV_STEP,    C_DIV_MORE, S_DIV,     C_NEVER,    S_IDLE, S_PICK_RD};
      S_PICK_RD: w = '{OP_RD_REM,      C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_PICK_WT};
      S_PICK_WT: w = '{OP_PICK,        C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_DONE};
      S_DONE:    w = '{OP_PUBLISH,     C_OUT_BUSY, S_DONE,    C_NEVER,    S_IDLE, S_IDLE};
      default:   w = '{OP_NOP,         C_NEVER,    S_IDLE,    C_NEVER,    S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: design/isrp_ram.sv
module isrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/indexed_set_with_random_pick_core.sv
// Add, remove and search scan the occupied entries in order; the scan reads one entry per cycle,
// and a remove that hits then reads the last entry and writes it into the freed slot.
// A random pick runs the 15-step bit-serial modulo; on an empty set it skips the modulo and reports empty.
// One item is in work at a time; the input is ready again when the result is loaded.
// Reset (synchronous, active low) clears the occupancy and the control state only;
// the store itself is not cleared and needs no clearing pass.
module indexed_set_with_random_pick_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cmd[1:0], value[33:2], random_pick[48:34], zero pad[55:49]
  input  logic [isrp_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[2:0], position[8:3], element[40:9], occupancy[47:41]
  output logic [isrp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import isrp_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  ucode_t            cw;

  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;
  logic              chk_r, chk_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [RNDC_W-1:0] bit_r, bit_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VAL_W-1:0]  elem_r, elem_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic              accept;
  logic              hit;
  logic              more;
  logic              out_free;
  logic              full;
  logic [CNT_W-1:0]  last;
  logic [CNT_W-1:0]  trial;
  logic              ok_a;
  logic              ok_b;

  // Value store
  isrp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status flags seen by the sequencer and the datapath
  assign cw        = ucode_rom(pc_r);
  assign in_tready = (pc_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign hit       = chk_r && (ram_rdata == val_r);
  assign more      = (idx_r < cnt_r);
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign last      = cnt_r - 1'b1;
  assign trial     = {rem_r[CNT_W-2:0], rnd_r[RND_W-1]};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Jump condition evaluation
  function automatic logic cond_eval(input cond_t c, input logic acc, input logic [CMD_W-1:0] icmd,
                                     input logic [CMD_W-1:0] rcmd, input logic h, input logic m,
                                     input logic f, input logic empty, input logic dmore,
                                     input logic busy);
    logic r;
    case (c)
      C_ALWAYS:   r = 1'b1;
      C_NEVER:    r = 1'b0;
      C_ACC_SCAN: r = acc && (icmd != CMD_PICK);
      C_ACC_PICK: r = acc && (icmd == CMD_PICK);
      C_HIT:      r = h;
      C_MORE:     r = m;
      C_ADD_FULL: r = (rcmd == CMD_ADD) && f;
      C_ADD:      r = (rcmd == CMD_ADD);
      C_REMOVE:   r = (rcmd == CMD_REMOVE);
      C_EMPTY:    r = empty;
      C_DIV_MORE: r = dmore;
      C_OUT_BUSY: r = busy;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  // Step counter with two conditional jumps per control word
  always_comb begin
    ok_a = cond_eval(cw.cond_a, accept, in_tdata[1:0], cmd_r, hit, more, full,
                     (cnt_r == '0), (bit_r != '0), !out_free);
    ok_b = cond_eval(cw.cond_b, accept, in_tdata[1:0], cmd_r, hit, more, full,
                     (cnt_r == '0), (bit_r != '0), !out_free);
    if (ok_a) begin
      pc_nxt = cw.tgt_a;
    end else if (ok_b) begin
      pc_nxt = cw.tgt_b;
    end else begin
      pc_nxt = cw.tgt_else;
    end
  end

  // Datapath driven by the current control word
  always_comb begin
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    rnd_nxt       = rnd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    chk_nxt       = chk_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    elem_nxt      = elem_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = val_r;
    ram_raddr     = '0;
    case (cw.op)
      OP_LOAD: begin
        if (accept) begin
          cmd_nxt    = in_tdata[1:0];
          val_nxt    = in_tdata[33:2];
          rnd_nxt    = in_tdata[48:34];
          idx_nxt    = '0;
          chk_nxt    = 1'b0;
          status_nxt = ST_DONE;
          pos_nxt    = '0;
          elem_nxt   = '0;
        end
      end
      OP_SCAN: begin
        // Issue one read per cycle; the compare sees last cycle's entry.
        if (!hit) begin
          if (more) begin
            ram_raddr = idx_r[ADDR_W-1:0];
            slot_nxt  = idx_r[ADDR_W-1:0];
            idx_nxt   = idx_r + 1'b1;
            chk_nxt   = 1'b1;
          end else begin
            chk_nxt = 1'b0;
          end
        end
      end
      OP_SET_NF: begin
        status_nxt = ST_NOT_FOUND;
      end
      OP_SET_FULL: begin
        status_nxt = ST_FULL;
      end
      OP_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[ADDR_W-1:0];
        pos_nxt   = POS_W'(cnt_r[ADDR_W-1:0]);
        cnt_nxt   = cnt_r + 1'b1;
      end
      OP_SET_PRESENT: begin
        status_nxt = ST_PRESENT;
        pos_nxt    = POS_W'(slot_r);
      end
      OP_SET_HIT: begin
        pos_nxt = POS_W'(slot_r);
      end
      OP_RD_LAST: begin
        ram_raddr = last[ADDR_W-1:0];
      end
      OP_RM_WR: begin
        // Move the last entry into the freed slot; a self-move when it is the last.
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        cnt_nxt   = last;
        pos_nxt   = POS_W'(slot_r);
      end
      OP_DIV_INIT: begin
        rem_nxt = '0;
        bit_nxt = RNDC_W'(RND_W - 1);
      end
      OP_SET_EMPTY: begin
        status_nxt = ST_EMPTY;
      end
      OP_DIV_STEP: begin
        // Restoring modulo, one bit of the random number per step.
        if (trial >= cnt_r) begin
          rem_nxt = trial - cnt_r;
        end else begin
          rem_nxt = trial;
        end
        rnd_nxt = {rnd_r[RND_W-2:0], 1'b0};
        bit_nxt = bit_r - 1'b1;
      end
      OP_RD_REM: begin
        ram_raddr = rem_r[ADDR_W-1:0];
      end
      OP_PICK: begin
        elem_nxt = ram_rdata;
        pos_nxt  = POS_W'(rem_r[ADDR_W-1:0]);
      end
      OP_PUBLISH: begin
        if (out_free) begin
          out_data_nxt  = {cnt_r, elem_r, pos_r, status_r};
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      cnt_r       <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    rnd_r      <= rnd_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
    elem_r     <= elem_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // The occupancy never goes beyond the store.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("occupancy exceeds capacity");

  // The occupancy moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ((cnt_r == $past(cnt_r) + 1'b1) ||
                                 (cnt_r + 1'b1 == $past(cnt_r))))
    else $error("occupancy jumped");

  // Failing commands report position zero and no element.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[2:0] == ST_NOT_FOUND || out_data_r[2:0] == ST_FULL ||
                     out_data_r[2:0] == ST_EMPTY)) |-> (out_data_r[40:3] == '0))
    else $error("failed command carries position or element");
`endif

endmodule

FILE: tb/tb_indexed_set_with_random_pick_core.sv
`timescale 1ns / 100ps

module tb_indexed_set_with_random_pick_core;

  import isrp_pkg::*;

  // One result word, split into its fields.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  element;
    logic [CNT_W-1:0]  occupancy;
  } set_reply_t;

  // Mirrors the set contents and holds the replies still owed by the block.
  class set_tracker;
    logic [VAL_W-1:0] entries [CAPACITY];
    int               count;
    set_reply_t       expected_replies [$];
    int               mismatches;
    int               replies_checked;
    int               status_tally [8];

    function new();
      count = 0;
      mismatches = 0;
      replies_checked = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // Slot holding v among the occupied entries, or -1 when absent.
    function int find_slot(logic [VAL_W-1:0] v);
      for (int i = 0; i < count; i++) begin
        if (entries[i] == v) return i;
      end
      return -1;
    endfunction

    // Applies one accepted input word to the mirror and queues its reply.
    function void note_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v, logic [RND_W-1:0] rnd);
      set_reply_t r;
      int         slot;
      int         pick;
      r = '0;
      slot = find_slot(v);
      case (cmd)
        CMD_ADD: begin
          if (slot >= 0) begin
            r.status = ST_PRESENT;
            r.position = POS_W'(slot);
          end else if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            r.status = ST_DONE;
            r.position = POS_W'(count);
            entries[count] = v;
            count++;
          end
        end
        CMD_REMOVE: begin
          if (slot >= 0) begin
            // The last entry fills the hole; removing the last one just shrinks.
            entries[slot] = entries[count - 1];
            count--;
            r.status = ST_DONE;
            r.position = POS_W'(slot);
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        CMD_SEARCH: begin
          if (slot >= 0) begin
            r.status = ST_DONE;
            r.position = POS_W'(slot);
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        CMD_PICK: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pick = int'(rnd) % count;
            r.status = ST_DONE;
            r.position = POS_W'(pick);
            r.element = entries[pick];
          end
        end
        default: begin
        end
      endcase
      r.occupancy = CNT_W'(count);
      expected_replies.insert(expected_replies.size(), r);
    endfunction

    // Compares one result word against the oldest outstanding reply.
    function void check_word(set_reply_t got);
      set_reply_t exp;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result status %0d position %0d element %h occupancy %0d",
                   got.status, got.position, got.element, got.occupancy);
        return;
      end
      exp = expected_replies.pop_front();
      replies_checked++;
      status_tally[exp.status]++;
      if (got.status !== exp.status || got.position !== exp.position ||
          got.element !== exp.element || got.occupancy !== exp.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch on result %0d: expected status %0d position %0d element %h ",
                    "occupancy %0d, got status %0d position %0d element %h occupancy %0d"},
                   replies_checked, exp.status, exp.position, exp.element, exp.occupancy,
                   got.status, got.position, got.element, got.occupancy);
      end
    endfunction
  endclass

  localparam int ITEM_TARGET = 1750;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 400;
  localparam int PAD_W       = IN_TDATA_W - CMD_W - VAL_W - RND_W;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  set_tracker  board;
  int          words_sent = 0;
  int          replies_seen = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          valid_up = 1'b0;

  always #5 clk = ~clk;

  indexed_set_with_random_pick_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Offers one word and returns once it is taken; bursts end in a random gap.
  task automatic offer(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v,
                       input logic [RND_W-1:0] r);
    in_tvalid <= 1'b1;
    in_tdata <= {{PAD_W{1'b0}}, r, v, c};
    valid_up = 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_word(c, v, r);
    words_sent++;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      valid_up = 1'b0;
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(20, 90)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Small signed values collide often; the extremes show up now and then.
  function automatic logic [VAL_W-1:0] narrow_value();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return VAL_W'($urandom_range(0, 15) - 8);
  endfunction

  // A value currently in the set, or a fresh one if the set is empty.
  function automatic logic [VAL_W-1:0] stored_value();
    if (board.count == 0) return $urandom();
    return board.entries[$urandom_range(0, board.count - 1)];
  endfunction

  // One random word with the given command weights.
  task automatic random_item(input int w_add, input int w_rm, input int w_srch,
                             input int w_pick);
    int               roll;
    int               vm;
    logic [CMD_W-1:0] c;
    logic [VAL_W-1:0] v;
    logic [RND_W-1:0] r;
    roll = $urandom_range(0, w_add + w_rm + w_srch + w_pick - 1);
    vm = $urandom_range(0, 99);
    if (roll < w_add) c = CMD_ADD;
    else if (roll < w_add + w_rm) c = CMD_REMOVE;
    else if (roll < w_add + w_rm + w_srch) c = CMD_SEARCH;
    else c = CMD_PICK;
    case (c)
      CMD_ADD:    v = (vm < 75) ? $urandom() : (vm < 90) ? stored_value() : narrow_value();
      CMD_REMOVE: v = (vm < 70) ? stored_value() : (vm < 85) ? narrow_value() : $urandom();
      CMD_SEARCH: v = (vm < 50) ? stored_value() : (vm < 75) ? narrow_value() : $urandom();
      default:    v = $urandom();
    endcase
    r = $urandom_range(0, 1) ? RND_W'($urandom()) : RND_W'($urandom_range(0, 127));
    offer(c, v, r);
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_word('{status: out_tdata[2:0], position: out_tdata[8:3],
                         element: out_tdata[40:9], occupancy: out_tdata[47:41]});
      replies_seen++;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: stall patterns that change at random intervals, plus one long hold.
  initial begin
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        if (!held && replies_seen >= HOLD_AFTER) begin
          // Keep the output blocked so the core backs up into its input.
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          out_tready <= 1'b1;
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= $urandom_range(0, 1);
            2: out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= ~out_tready;
          endcase
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int n;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty set: pick, remove and search all miss.
    offer(CMD_PICK, 32'h0000_0000, 15'h7FFF);
    offer(CMD_REMOVE, 32'h0000_0005, 15'h0000);
    offer(CMD_SEARCH, 32'h0000_0000, 15'h0000);
    // Extremes of the value field.
    offer(CMD_ADD, 32'h8000_0000, 15'h0000);
    offer(CMD_ADD, 32'h7FFF_FFFF, 15'h0000);
    offer(CMD_ADD, 32'hFFFF_FFFF, 15'h0000);
    offer(CMD_ADD, 32'h0000_0000, 15'h0000);
    // Adding a value already present reports its slot.
    offer(CMD_ADD, 32'h7FFF_FFFF, 15'h0000);
    offer(CMD_SEARCH, 32'hFFFF_FFFF, 15'h0000);
    offer(CMD_SEARCH, 32'h0000_3039, 15'h0000);
    // Pick with both extremes of the random number.
    offer(CMD_PICK, 32'h0000_0000, 15'h7FFF);
    offer(CMD_PICK, 32'hFFFF_FFFF, 15'h0000);
    // Remove from the front moves the last entry into the hole.
    offer(CMD_REMOVE, 32'h8000_0000, 15'h0000);
    offer(CMD_SEARCH, 32'h0000_0000, 15'h0000);
    // Remove of the last entry, then of an absent value.
    offer(CMD_REMOVE, 32'hFFFF_FFFF, 15'h0000);
    offer(CMD_REMOVE, 32'h0000_0012, 15'h0000);
    offer(CMD_REMOVE, 32'h7FFF_FFFF, 15'h0000);
    offer(CMD_PICK, 32'h0000_0000, 15'h5555);
    // Remove of the only entry empties the set.
    offer(CMD_REMOVE, 32'h0000_0000, 15'h0000);
    offer(CMD_PICK, 32'h0000_0000, 15'h2AAA);
    offer(CMD_SEARCH, 32'h8000_0000, 15'h0000);

    // Random rounds: fill to full, churn, drain to empty, churn again.
    while (words_sent < ITEM_TARGET) begin
      n = 0;
      while (board.count < CAPACITY && n < 400 && words_sent < ITEM_TARGET) begin
        random_item(60, 10, 15, 15);
        n++;
      end
      repeat (8) if (words_sent < ITEM_TARGET) random_item(70, 5, 15, 10);
      repeat (120) if (words_sent < ITEM_TARGET) random_item(25, 25, 25, 25);
      n = 0;
      while (board.count > 0 && n < 400 && words_sent < ITEM_TARGET) begin
        random_item(10, 60, 15, 15);
        n++;
      end
      repeat (6) if (words_sent < ITEM_TARGET) random_item(10, 30, 20, 40);
      repeat (60) if (words_sent < ITEM_TARGET) random_item(30, 20, 25, 25);
    end
    if (valid_up) in_tvalid <= 1'b0;

    // Drain outstanding replies, then watch a while for stray results.
    while (board.expected_replies.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("run covered %0d words in and %0d results checked, %0d mismatches",
             words_sent, board.replies_checked, board.mismatches);
    $display("replies by kind: done %0d, present %0d, not found %0d, full %0d, empty %0d",
             board.status_tally[ST_DONE], board.status_tally[ST_PRESENT],
             board.status_tally[ST_NOT_FOUND], board.status_tally[ST_FULL],
             board.status_tally[ST_EMPTY]);
    if (board.mismatches == 0 && board.expected_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: indexed_set_with_random_pick_core.f
design/isrp_pkg.sv
design/isrp_ram.sv
design/indexed_set_with_random_pick_core.sv
tb/tb_indexed_set_with_random_pick_core.sv
